/* design/msss_pkg.sv */
package msss_pkg;

   // Display geometry and flash timing
   localparam int NUM_DIGITS     = 3;
   localparam int FLASH_PERIOD   = 200;
   localparam int FLASH_ON_START = 100;

   // Field widths
   localparam int IDX_W   = 2;
   localparam int CODE_W  = 4;
   localparam int EN_W    = 3;
   localparam int SEG_W   = 8;
   localparam int TIMER_W = 8;
   localparam int KIND_W  = 2;
   localparam int CNT_W   = $clog2(SEG_W + 1);

   // Request commands
   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // Response kinds
   localparam logic [KIND_W-1:0] KIND_SERIAL = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LATCH  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_BLANK  = 2'd2;

   localparam logic [EN_W-1:0]  ALL_OFF   = '1;
   localparam logic [SEG_W-1:0] SEG_BLANK = 8'hff;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // One display job handed from front to back
   typedef struct packed {
      logic             blank;
      logic [SEG_W-1:0] seg;
      logic [EN_W-1:0]  en_n;
   } job_type;

   // Active-low segment pattern, bit 7 is the decimal point
   function automatic logic [SEG_W-1:0] seg_decode(input logic [CODE_W-1:0] code);
      logic [SEG_W-1:0] seg;
      case (code)
         4'd0:    seg = 8'hc0;
         4'd1:    seg = 8'hf9;
         4'd2:    seg = 8'ha4;
         4'd3:    seg = 8'hb0;
         4'd4:    seg = 8'h99;
         4'd5:    seg = 8'h92;
         4'd6:    seg = 8'h82;
         4'd7:    seg = 8'hf8;
         4'd8:    seg = 8'h80;
         4'd9:    seg = 8'h90;
         4'd10:   seg = 8'h8e;
         4'd11:   seg = 8'h88;
         default: seg = SEG_BLANK;
      endcase
      return seg;
   endfunction

   // Active-low enable that lights only the given digit
   function automatic logic [EN_W-1:0] digit_select(input logic [IDX_W-1:0] idx);
      return ALL_OFF & ~(EN_W'(1) << idx);
   endfunction

endpackage

/* design/multiplexed_seven_segment_scanner_unit.sv */
// Path: a tick's job is held in the queue, then in the back-end registers, before
//   its first response appears. Throughput: a scanning tick yields 9 responses,
//   one per cycle while rsp_ready is high, so the back-end serializer sets the rate;
//   a blank tick yields one; digit writes and quiet ticks stay in the front end.
// Reset: synchronous, active high; clears digits, scan index, flash timer,
//   flash enable and the job queue.
module multiplexed_seven_segment_scanner_unit (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_cmd,
   input  logic [msss_pkg::IDX_W-1:0]    req_digit_index,
   input  logic [msss_pkg::CODE_W-1:0]   req_digit_code,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [msss_pkg::KIND_W-1:0]   rsp_kind,
   output logic                          rsp_serial_bit,
   output logic [msss_pkg::EN_W-1:0]     rsp_digit_enable_n,
   output logic                          rsp_last,
   // configuration write
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_flash_enable
);

   // Front end -> queue: classified display jobs (scan a digit or blank all)
   logic              push_valid;
   logic              push_ready;
   msss_pkg::job_type push_job;

   // Queue -> back end
   logic              pop_valid;
   logic              pop_ready;
   msss_pkg::job_type pop_job;

   // Front: take requests, update digit store, scan index and flash timer,
   // and decode the selected digit into a job.
   msss_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_digit_index  (req_digit_index),
      .req_digit_code   (req_digit_code),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_flash_enable (csr_flash_enable),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_job         (push_job)
   );

   // Queue: hold jobs so the front takes requests while the back drains, until full.
   msss_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   // Back: shift the segment byte out MSB first, then latch the selected digit;
   // a blank job gives one blank-all response.
   msss_back u_back (
      .clock              (clock),
      .reset              (reset),
      .pop_valid          (pop_valid),
      .pop_ready          (pop_ready),
      .pop_job            (pop_job),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_serial_bit     (rsp_serial_bit),
      .rsp_digit_enable_n (rsp_digit_enable_n),
      .rsp_last           (rsp_last)
   );

endmodule

/* design/msss_front.sv */
module msss_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_cmd,
   input  logic [msss_pkg::IDX_W-1:0]      req_digit_index,
   input  logic [msss_pkg::CODE_W-1:0]     req_digit_code,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic                            csr_flash_enable,
   output logic                            push_valid,
   input  logic                            push_ready,
   output msss_pkg::job_type               push_job
);

   logic                              flash_enable_ff, flash_enable_in;
   logic [msss_pkg::IDX_W-1:0]        scan_index_ff, scan_index_in;
   logic [msss_pkg::TIMER_W-1:0]      flash_timer_ff, flash_timer_in;
   logic [msss_pkg::CODE_W-1:0]       digit_store_ff [msss_pkg::NUM_DIGITS];
   logic [msss_pkg::CODE_W-1:0]       digit_store_in [msss_pkg::NUM_DIGITS];

   logic                              accept;
   logic [msss_pkg::IDX_W-1:0]        next_index;
   logic [msss_pkg::TIMER_W-1:0]      timer_inc;
   logic                              do_scan;
   logic                              do_blank;

   assign req_ready = push_ready;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;

   always_comb begin
      flash_enable_in = (csr_valid && csr_ready) ? csr_flash_enable : flash_enable_ff;
      scan_index_in   = scan_index_ff;
      flash_timer_in  = flash_timer_ff;
      digit_store_in  = digit_store_ff;
      do_scan         = 1'b0;
      do_blank        = 1'b0;
      next_index      = (scan_index_ff == msss_pkg::IDX_W'(msss_pkg::NUM_DIGITS - 1))
                        ? '0 : scan_index_ff + 1'b1;
      timer_inc       = flash_timer_ff + 1'b1;

      if (accept) begin
         if (req_cmd == msss_pkg::CMD_WRITE) begin
            // drop writes to digits that do not exist
            if (req_digit_index < msss_pkg::IDX_W'(msss_pkg::NUM_DIGITS)) begin
               digit_store_in[req_digit_index] = req_digit_code;
            end
         end else if (flash_enable_ff) begin
            flash_timer_in = timer_inc;
            if (timer_inc >= msss_pkg::TIMER_W'(msss_pkg::FLASH_PERIOD)) begin
               flash_timer_in = '0;
               do_blank       = 1'b1;
            end else if (timer_inc >= msss_pkg::TIMER_W'(msss_pkg::FLASH_ON_START)) begin
               do_scan = 1'b1;
            end
         end else begin
            do_scan = 1'b1;
         end
      end

      if (do_scan) begin
         scan_index_in = next_index;
      end

      push_valid     = do_scan || do_blank;
      push_job.blank = do_blank;
      push_job.seg   = msss_pkg::seg_decode(digit_store_ff[next_index]);
      push_job.en_n  = do_blank ? msss_pkg::ALL_OFF : msss_pkg::digit_select(next_index);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flash_enable_ff <= 1'b0;
         scan_index_ff   <= '0;
         flash_timer_ff  <= '0;
         for (int i = 0; i < msss_pkg::NUM_DIGITS; i++) begin
            digit_store_ff[i] <= '0;
         end
      end else begin
         flash_enable_ff <= flash_enable_in;
         scan_index_ff   <= scan_index_in;
         flash_timer_ff  <= flash_timer_in;
         digit_store_ff  <= digit_store_in;
      end
   end

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      scan_index_ff < msss_pkg::IDX_W'(msss_pkg::NUM_DIGITS))
      else $error("scan index out of range");

   a_timer_range: assert property (@(posedge clock) disable iff (reset)
      flash_timer_ff < msss_pkg::TIMER_W'(msss_pkg::FLASH_PERIOD))
      else $error("flash timer beyond period");

   a_timer_hold: assert property (@(posedge clock) disable iff (reset)
      !flash_enable_ff |=> $stable(flash_timer_ff))
      else $error("flash timer moved while flashing is off");

endmodule

/* design/msss_queue.sv */
module msss_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  msss_pkg::job_type push_job,
   output logic              pop_valid,
   input  logic              pop_ready,
   output msss_pkg::job_type pop_job
);

   msss_pkg::job_type               entry_ff [msss_pkg::QUEUE_DEPTH];
   logic [msss_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [msss_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [msss_pkg::QCNT_W-1:0]     count_ff, count_in;
   logic                            push;
   logic                            pop;

   assign push_ready = (count_ff != msss_pkg::QCNT_W'(msss_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_job    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= msss_pkg::QCNT_W'(msss_pkg::QUEUE_DEPTH))
      else $error("queue count overflow");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == msss_pkg::QCNT_W'(msss_pkg::QUEUE_DEPTH))
      |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule

/* design/msss_back.sv */
module msss_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          pop_valid,
   output logic                          pop_ready,
   input  msss_pkg::job_type             pop_job,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [msss_pkg::KIND_W-1:0]   rsp_kind,
   output logic                          rsp_serial_bit,
   output logic [msss_pkg::EN_W-1:0]     rsp_digit_enable_n,
   output logic                          rsp_last
);

   logic                          busy_ff, busy_in;
   logic                          blank_ff, blank_in;
   logic [msss_pkg::SEG_W-1:0]    seg_ff, seg_in;
   logic [msss_pkg::EN_W-1:0]     en_n_ff, en_n_in;
   logic [msss_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic                          done;
   logic                          pop;

   always_comb begin
      rsp_valid = busy_ff;
      if (blank_ff) begin
         rsp_kind           = msss_pkg::KIND_BLANK;
         rsp_serial_bit     = 1'b0;
         rsp_digit_enable_n = msss_pkg::ALL_OFF;
         rsp_last           = 1'b1;
      end else if (cnt_ff < msss_pkg::CNT_W'(msss_pkg::SEG_W)) begin
         rsp_kind           = msss_pkg::KIND_SERIAL;
         rsp_serial_bit     = seg_ff[msss_pkg::SEG_W-1];
         rsp_digit_enable_n = msss_pkg::ALL_OFF;
         rsp_last           = 1'b0;
      end else begin
         rsp_kind           = msss_pkg::KIND_LATCH;
         rsp_serial_bit     = 1'b0;
         rsp_digit_enable_n = en_n_ff;
         rsp_last           = 1'b1;
      end
   end

   assign done      = busy_ff && rsp_ready && rsp_last;
   assign pop_ready = !busy_ff || done;
   assign pop       = pop_valid && pop_ready;

   always_comb begin
      busy_in  = busy_ff;
      blank_in = blank_ff;
      seg_in   = seg_ff;
      en_n_in  = en_n_ff;
      cnt_in   = cnt_ff;
      if (pop) begin
         busy_in  = 1'b1;
         blank_in = pop_job.blank;
         seg_in   = pop_job.seg;
         en_n_in  = pop_job.en_n;
         cnt_in   = '0;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (busy_ff && rsp_ready) begin
         // advance to the next segment bit
         seg_in = {seg_ff[msss_pkg::SEG_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      blank_ff <= blank_in;
      seg_ff   <= seg_in;
      en_n_ff  <= en_n_in;
      cnt_ff   <= cnt_in;
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff <= msss_pkg::CNT_W'(msss_pkg::SEG_W))
      else $error("bit counter past latch step");

   a_latch_one_digit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == msss_pkg::KIND_LATCH)
      |-> ($countones(~rsp_digit_enable_n) == 1))
      else $error("latch does not select exactly one digit");

   a_bit_then_next: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=> rsp_valid)
      else $error("response stream broken mid digit");

endmodule
